### rtl/core/rbf_pkg.sv
// Shared types and constants for the real-time byte filter with receive ring.
`default_nettype none

package rbf_pkg;

  localparam int BUFFER_BYTES_DEF = 128;
  localparam int COUNT_W          = 8;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 8;
  localparam int IN_DATA_W        = 16;
  localparam int IN_USER_W        = 2;
  localparam int OUT_DATA_W       = 40;

  localparam logic [7:0] ASCII_TOP = 8'h7F;

  // Operation codes carried on in_tuser
  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_RESET_CODE       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STATUS_CODE      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CYCLE_START_CODE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FEED_HOLD_CODE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_JOG_CANCEL_CODE  = 3'd4;

  localparam logic [6:0] RESET_CODE_RST       = 7'd24;
  localparam logic [6:0] STATUS_CODE_RST      = 7'd63;
  localparam logic [6:0] CYCLE_START_CODE_RST = 7'd126;
  localparam logic [6:0] FEED_HOLD_CODE_RST   = 7'd33;
  localparam logic [7:0] JOG_CANCEL_CODE_RST  = 8'd133;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } rbf_state_t;

  // Result word, first field in the highest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] used_count;
    logic               dropped_full;
    logic               queued;
    logic [7:0]         rt_code;
    logic               rt_valid;
    logic               read_valid;
    logic [7:0]         read_data;
  } rbf_result_t;

endpackage

`default_nettype wire

### rtl/core/realtime_byte_filter_rx_ring.sv
// Top level: real-time byte filter in front of a receive ring buffer.
`default_nettype none

// Each input word is a received line byte, a host read or a flush; each gives
// one result word with the used and free counts of the ring after the step.
// Bytes matching one of the four ASCII command registers, and bytes above
// 0x7F, come back as real-time codes and are not stored (the jog-cancel code
// only while jog_active is set, else it is discarded silently). The ring holds
// BUFFER_BYTES bytes in a single-port-write, registered-read memory of
// BUFFER_BYTES+1 entries. A received byte, a flush, an empty read or an unknown
// operation is answered from ST_IDLE; a read that pops a byte goes on to
// ST_READ, where the registered memory word is put into the result. Only one
// word is in flight at a time, and a new word is taken in the cycle the previous
// result leaves the output register. No clearing pass follows reset.
module realtime_byte_filter_rx_ring #(
  parameter int BUFFER_BYTES = rbf_pkg::BUFFER_BYTES_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // in_tdata: rx_byte [7:0], jog_active [8], zero [15:9]
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [rbf_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: func [1:0]
  input  wire  [rbf_pkg::IN_USER_W-1:0]   in_tuser,
  // out_tdata: read_data [7:0], read_valid [8], rt_valid [9], rt_code [17:10],
  //   queued [18], dropped_full [19], used_count [27:20], free_count [35:28],
  //   zero [39:36]
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [rbf_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  wire                             cfg_we,
  input  wire  [rbf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire  [rbf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import rbf_pkg::*;

  localparam int RING_SLOTS = BUFFER_BYTES + 1;
  localparam int PTR_W      = $clog2(RING_SLOTS);

  logic [7:0] ring_mem [RING_SLOTS];
  logic [7:0] rd_data_r;

  logic [6:0] reset_code_r, status_code_r, cycle_start_code_r, feed_hold_code_r;
  logic [7:0] jog_cancel_code_r;

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  rbf_state_t       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  rbf_result_t      res_r, res_nxt;

  logic             accept;
  logic             mem_we, mem_re;
  logic             load;
  logic [1:0]       func;
  logic [7:0]       rx_byte;
  logic             jog_active;
  logic             is_cmd;
  logic [PTR_W-1:0] wr_adv, rd_adv;
  logic [COUNT_W-1:0] wr_ext, rd_ext, used_cnt;

  assign func       = in_tuser;
  assign rx_byte    = in_tdata[7:0];
  assign jog_active = in_tdata[8];

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign is_cmd = (rx_byte == {1'b0, reset_code_r})       ||
                  (rx_byte == {1'b0, status_code_r})      ||
                  (rx_byte == {1'b0, cycle_start_code_r}) ||
                  (rx_byte == {1'b0, feed_hold_code_r});

  assign wr_adv = (wr_ptr_r == PTR_W'(RING_SLOTS - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_adv = (rd_ptr_r == PTR_W'(RING_SLOTS - 1)) ? '0 : rd_ptr_r + PTR_W'(1);

  // Counts follow the pointers as they stand after this word
  assign wr_ext   = COUNT_W'(wr_ptr_nxt);
  assign rd_ext   = COUNT_W'(rd_ptr_nxt);
  assign used_cnt = (wr_ext >= rd_ext) ? (wr_ext - rd_ext)
                                       : (COUNT_W'(RING_SLOTS) - (rd_ext - wr_ext));

  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load       = 1'b0;
    res_nxt    = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (func)
            FUNC_RX: begin
              if (is_cmd) begin
                res_nxt.rt_valid = 1'b1;
                res_nxt.rt_code  = rx_byte;
              end else if (rx_byte > ASCII_TOP) begin
                // drop a jog cancel silently unless jogging
                if (rx_byte != jog_cancel_code_r || jog_active) begin
                  res_nxt.rt_valid = 1'b1;
                  res_nxt.rt_code  = rx_byte;
                end
              end else if (wr_adv != rd_ptr_r) begin
                mem_we         = 1'b1;
                wr_ptr_nxt     = wr_adv;
                res_nxt.queued = 1'b1;
              end else begin
                res_nxt.dropped_full = 1'b1;
              end
            end
            FUNC_READ: begin
              if (wr_ptr_r != rd_ptr_r) begin
                // wait in ST_READ for the registered memory word
                mem_re     = 1'b1;
                rd_ptr_nxt = rd_adv;
                load       = 1'b0;
                state_nxt  = ST_READ;
              end
            end
            FUNC_FLUSH: rd_ptr_nxt = wr_ptr_r;
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (!out_valid_r || out_tready) begin
          load               = 1'b1;
          res_nxt.read_data  = rd_data_r;
          res_nxt.read_valid = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    res_nxt.used_count = used_cnt;
    res_nxt.free_count = COUNT_W'(BUFFER_BYTES) - used_cnt;
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_ptr_r] <= rx_byte;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_code_r       <= RESET_CODE_RST;
      status_code_r      <= STATUS_CODE_RST;
      cycle_start_code_r <= CYCLE_START_CODE_RST;
      feed_hold_code_r   <= FEED_HOLD_CODE_RST;
      jog_cancel_code_r  <= JOG_CANCEL_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RESET_CODE:       reset_code_r       <= cfg_wdata[6:0];
        REG_STATUS_CODE:      status_code_r      <= cfg_wdata[6:0];
        REG_CYCLE_START_CODE: cycle_start_code_r <= cfg_wdata[6:0];
        REG_FEED_HOLD_CODE:   feed_hold_code_r   <= cfg_wdata[6:0];
        REG_JOG_CANCEL_CODE:  jog_cancel_code_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

endmodule

`default_nettype wire

### rtl/core/rbf_checker.sv
// Port-level checks for the real-time byte filter, bound to the top level.
`default_nettype none

module rbf_checker #(
  parameter int BUFFER_BYTES = rbf_pkg::BUFFER_BYTES_DEF
) (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [rbf_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import rbf_pkg::*;

  rbf_result_t res;
  assign res = out_tdata;

  // counts always add up to the ring size
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.used_count + res.free_count) == COUNT_W'(BUFFER_BYTES))
    else $error("used and free counts do not add up to the buffer size");

  // a word has at most one outcome
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0({res.read_valid, res.rt_valid, res.queued, res.dropped_full}))
    else $error("more than one outcome flag set");

  // payload bytes are zero unless flagged
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((res.read_valid || res.read_data == 8'd0) &&
                    (res.rt_valid || res.rt_code == 8'd0)))
    else $error("unflagged byte field is not zero");

  // a stored byte leaves the ring non-empty, a dropped one leaves it full
  a_queue_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((!res.queued || res.used_count != '0) &&
                    (!res.dropped_full || res.free_count == '0)))
    else $error("queue flags disagree with counts");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

endmodule

bind realtime_byte_filter_rx_ring rbf_checker #(
  .BUFFER_BYTES(BUFFER_BYTES)
) u_rbf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
